// ===== rtl/kst_pkg.sv =====
// Shared types and constants for the keyed slot table.
// Holds the controller state enum, the command/status structs and the result codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

	localparam int ACTIVE_SIZE_W = 7;
	localparam logic [ACTIVE_SIZE_W-1:0] ACTIVE_SIZE_RESET = 7'd64;

	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 6;
	localparam int IN_KEY_W = 32;
	localparam int IN_VAL_W = 32;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 16;

	localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FREED     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_WRITE
	} kst_state_t;

	typedef struct packed {
		logic load_req;
		logic match;
		logic commit;
	} kst_cmd_t;

	typedef struct packed {
		logic out_busy;
	} kst_stat_t;

endpackage

`default_nettype wire

// ===== rtl/keyed_slot_table_unit.sv =====
// Keyed slot table: top level joining the controller and the datapath.
// Depends on kst_pkg, kst_ctrl and kst_datapath.
//
// Usage:
//   Requests enter on the s_ stream (s_tdata: mode, key, value from bit 0 up).
//   Each request yields one result word on the m_ stream (status, slot).
//   Allocate updates the lowest active slot with a matching key, else claims
//   the lowest inactive slot, else reports the table full. Free clears every
//   matching active slot and reports the lowest one.
//   A request is compared against all slots in parallel in the cycle after
//   acceptance and then written back, which loads the result register. A new
//   request can be accepted in the cycle the previous one is written back, not
//   before, as the compare stage is followed by the write-back stage.
//   While a result waits on m_tready, the next request is still accepted and
//   compared, then holds at write-back until the result register is free.
//   Reset clears all active marks and sets active_size to 64; no sweep is
//   needed. cfg_we writes active_size; the user must keep it to idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module keyed_slot_table_unit import kst_pkg::*; #(
	parameter int SLOTS      = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [S_TDATA_W-1:0]     s_tdata,   // mode[0], key[32:1], value[64:33]
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [M_TDATA_W-1:0]          m_tdata,   // status[2:0], slot[8:3]
	input  wire logic                     cfg_we,
	input  wire logic [ACTIVE_SIZE_W-1:0] cfg_wdata
);

	kst_cmd_t  cmd;
	kst_stat_t stat;

	kst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kst_datapath #(
		.SLOTS      (SLOTS),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

// ===== rtl/kst_ctrl.sv =====
// Controller state machine for the keyed slot table.
// Sequences request load, match and write-back; depends on kst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kst_ctrl import kst_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire kst_stat_t stat,
	output kst_cmd_t       cmd
);

	kst_state_t state_q;
	kst_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_next = ST_MATCH;
				end
			end
			ST_MATCH: begin
				state_next = ST_WRITE;
			end
			ST_WRITE: begin
				// A new word may enter in the same cycle the previous one commits.
				if (!stat.out_busy) begin
					state_next = s_tvalid ? ST_MATCH : ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.match    = 1'b0;
		cmd.commit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
			end
			ST_WRITE: begin
				s_tready   = !stat.out_busy;
				cmd.commit = !stat.out_busy;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
		cmd.load_req = s_tvalid && s_tready;
	end

endmodule

`default_nettype wire

// ===== rtl/kst_datapath.sv =====
// Datapath of the keyed slot table: slot storage, parallel key compare,
// priority encode, write-back and the result register. Depends on kst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kst_datapath import kst_pkg::*; #(
	parameter int SLOTS      = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire kst_cmd_t                 cmd,
	output kst_stat_t                     stat,
	input  wire logic [S_TDATA_W-1:0]     s_tdata,
	input  wire logic                     cfg_we,
	input  wire logic [ACTIVE_SIZE_W-1:0] cfg_wdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [M_TDATA_W-1:0]          m_tdata
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CMP_W = (IDX_W + 1 > ACTIVE_SIZE_W) ? IDX_W + 1 : ACTIVE_SIZE_W;

	logic [ACTIVE_SIZE_W-1:0] active_size_q;

	// Request register, loaded on accept.
	logic                  mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// Match stage.
	logic                  mode_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [SLOTS-1:0]      hit_s1;
	logic [SLOTS-1:0]      free_s1;

	logic [KEY_BITS-1:0]   slot_key_q [SLOTS];
	logic [VALUE_BITS-1:0] slot_value_q [SLOTS];
	logic [SLOTS-1:0]      slot_active_q;

	logic [SLOTS-1:0] in_range;
	logic [SLOTS-1:0] hit_now;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] free_idx;
	logic             any_hit;
	logic             any_free;

	logic                m_tvalid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= ACTIVE_SIZE_RESET;
		end else if (cfg_we) begin
			active_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q  <= s_tdata[0];
			key_q   <= KEY_BITS'(s_tdata[IN_KEY_W:1]);
			value_q <= VALUE_BITS'(s_tdata[IN_KEY_W+IN_VAL_W:IN_KEY_W+1]);
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			in_range[i] = CMP_W'(i) < CMP_W'(active_size_q);
			hit_now[i]  = in_range[i] && slot_active_q[i] && (slot_key_q[i] == key_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			mode_s1  <= mode_q;
			key_s1   <= key_q;
			value_s1 <= value_q;
			hit_s1   <= hit_now;
			free_s1  <= in_range & ~slot_active_q;
		end
	end

	// Lowest set bit wins in both vectors.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_s1[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (free_s1[i]) begin
				free_idx = IDX_W'(i);
			end
		end
		any_hit  = |hit_s1;
		any_free = |free_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_active_q <= '0;
		end else if (cmd.commit) begin
			if (mode_s1 == MODE_FREE) begin
				slot_active_q <= slot_active_q & ~hit_s1;
			end else if (!any_hit && any_free) begin
				slot_active_q[free_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && mode_s1 == MODE_ALLOC) begin
			if (any_hit) begin
				slot_value_q[hit_idx] <= value_s1;
			end else if (any_free) begin
				slot_key_q[free_idx]   <= key_s1;
				slot_value_q[free_idx] <= value_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (mode_s1 == MODE_FREE) begin
				status_q <= any_hit ? STAT_FREED : STAT_NOT_FOUND;
				slot_q   <= any_hit ? SLOT_W'(hit_idx) : '0;
			end else if (any_hit) begin
				status_q <= STAT_UPDATED;
				slot_q   <= SLOT_W'(hit_idx);
			end else if (any_free) begin
				status_q <= STAT_INSERTED;
				slot_q   <= SLOT_W'(free_idx);
			end else begin
				status_q <= STAT_FULL;
				slot_q   <= '0;
			end
		end
	end

	assign stat.out_busy = m_tvalid_q && !m_tready;
	assign m_tvalid      = m_tvalid_q;
	assign m_tdata       = {{(M_TDATA_W - STATUS_W - SLOT_W){1'b0}}, slot_q, status_q};

endmodule

`default_nettype wire

// ===== bench/tb_keyed_slot_table_unit.sv =====
// Self-checking bench for keyed_slot_table_unit: allocate, update and free requests
// are checked against a shadow copy of the slot table under several active sizes.
// Depends on kst_pkg and the keyed_slot_table_unit RTL.
`timescale 1ns / 1ps

module tb_keyed_slot_table_unit;
	import kst_pkg::*;

	localparam int NUM_SLOTS  = 64;
	localparam int IDLE_LIMIT = 3000;
	localparam int MAX_REPORT = 10;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
	} slot_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [S_TDATA_W-1:0]     s_tdata = '0;   // mode, key, value from bit 0 up
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [M_TDATA_W-1:0]     m_tdata;        // status, slot from bit 0 up
	logic                     cfg_we = 1'b0;
	logic [ACTIVE_SIZE_W-1:0] cfg_wdata = '0;

	// Shadow copy of the slot table and its active size.
	logic [IN_KEY_W-1:0]      shadow_key [NUM_SLOTS];
	logic [IN_VAL_W-1:0]      shadow_value [NUM_SLOTS];
	bit                       shadow_active [NUM_SLOTS];
	logic [ACTIVE_SIZE_W-1:0] shadow_size = ACTIVE_SIZE_RESET;

	slot_result_t    pending_results [$];
	logic [31:0]     key_pool [$];
	int              mismatch_count = 0;
	int              idle_cycles = 0;
	int              rx_hold = 0;
	int              rx_stall = 0;
	bit              tx_gaps_on = 1'b1;
	bit              rx_gaps_on = 1'b1;

	keyed_slot_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic slot_result_t table_predict(logic mode, logic [31:0] key,
			logic [31:0] value);
		slot_result_t res;
		int span;
		bit hit;
		span = (shadow_size > NUM_SLOTS) ? NUM_SLOTS : shadow_size;
		hit = 1'b0;
		res.slot = '0;
		if (mode == MODE_ALLOC) begin
			res.status = STAT_FULL;
			for (int i = 0; i < span && !hit; i++) begin
				if (shadow_active[i] && shadow_key[i] == key) begin
					shadow_value[i] = value;
					res.status = STAT_UPDATED;
					res.slot = i[SLOT_W-1:0];
					hit = 1'b1;
				end
			end
			for (int i = 0; i < span && !hit; i++) begin
				if (!shadow_active[i]) begin
					shadow_key[i] = key;
					shadow_value[i] = value;
					shadow_active[i] = 1'b1;
					res.status = STAT_INSERTED;
					res.slot = i[SLOT_W-1:0];
					hit = 1'b1;
				end
			end
		end else begin
			// A free clears every matching slot but reports only the lowest.
			for (int i = 0; i < span; i++) begin
				if (shadow_active[i] && shadow_key[i] == key) begin
					shadow_active[i] = 1'b0;
					if (!hit) begin
						res.slot = i[SLOT_W-1:0];
						hit = 1'b1;
					end
				end
			end
			res.status = hit ? STAT_FREED : STAT_NOT_FOUND;
		end
		return res;
	endfunction

	task automatic note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORT)
			$display("%0t ns: mismatch: %s", $realtime, what);
	endtask

	// Result checker.
	always @(posedge clk) begin
		slot_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result word %h", m_tdata));
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tdata[2:0] !== exp_res.status)
					note_mismatch($sformatf("status expected %0d, got %0d",
						exp_res.status, m_tdata[2:0]));
				if (m_tdata[8:3] !== exp_res.slot)
					note_mismatch($sformatf("slot expected %0d, got %0d",
						exp_res.slot, m_tdata[8:3]));
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold-off on request.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else if (rx_gaps_on && $urandom_range(0, 9) == 0) begin
			rx_stall = $urandom_range(1, 19) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	// Called at a falling edge; returns at a falling edge with s_tvalid possibly
	// still high, so the caller sends again or lowers it in the same step.
	task automatic send_request(logic mode, logic [31:0] key, logic [31:0] value);
		s_tdata <= {{(S_TDATA_W - 65){1'b0}}, value, key, mode};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(table_predict(mode, key, value));
		@(negedge clk);
		if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_active_size(logic [ACTIVE_SIZE_W-1:0] size);
		drain_results();
		cfg_wdata <= size;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_size = size;
		@(negedge clk);
	endtask

	task automatic test_basic_ops();
		send_request(MODE_ALLOC, 32'h0000_0000, 32'h7FFF_FFFF);
		send_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'h8000_0000);
		send_request(MODE_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(MODE_FREE,  32'hFFFF_FFFF, 32'h0000_0000);
		send_request(MODE_FREE,  32'h0001_2345, 32'h5555_5555);
		send_request(MODE_ALLOC, 32'h0000_0005, 32'h0000_0000);
		drain_results();
	endtask

	task automatic test_size_edges();
		// With no slots in range, allocate is full and free finds nothing.
		write_active_size(7'd0);
		send_request(MODE_ALLOC, 32'h0000_0000, 32'h1234_5678);
		send_request(MODE_FREE,  32'h0000_0000, 32'h0000_0000);
		write_active_size(7'd1);
		send_request(MODE_ALLOC, 32'h0000_0000, 32'hAAAA_AAAA);
		send_request(MODE_ALLOC, 32'h0000_0009, 32'h0000_0001);
		drain_results();
	endtask

	task automatic test_duplicate_keys();
		// Shrinking the range lets one key land in two slots; a free clears both.
		write_active_size(7'd64);
		send_request(MODE_FREE,  32'h0000_0000, 32'h0);
		send_request(MODE_FREE,  32'h0000_0005, 32'h0);
		send_request(MODE_ALLOC, 32'hA5A5_0001, 32'h11);
		send_request(MODE_ALLOC, 32'hA5A5_0002, 32'h22);
		send_request(MODE_ALLOC, 32'hA5A5_0003, 32'h33);
		write_active_size(7'd2);
		send_request(MODE_FREE,  32'hA5A5_0001, 32'h0);
		send_request(MODE_ALLOC, 32'hA5A5_0003, 32'h44);
		write_active_size(7'd127);
		send_request(MODE_ALLOC, 32'hA5A5_0003, 32'h55);
		send_request(MODE_FREE,  32'hA5A5_0003, 32'h0);
		send_request(MODE_FREE,  32'hA5A5_0003, 32'h0);
		drain_results();
	endtask

	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		@(posedge clk);
		rx_hold = 400;
		@(negedge clk);
		for (int i = 0; i < 30; i++)
			send_request(1'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom);
		drain_results();
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_phase(logic [ACTIVE_SIZE_W-1:0] size, int count, bit gaps);
		int span;
		int pick;
		logic mode;
		logic [31:0] key;
		write_active_size(size);
		tx_gaps_on = gaps;
		rx_gaps_on = gaps;
		span = (size > NUM_SLOTS) ? NUM_SLOTS : size;
		// A pool a bit larger than the range keeps the table near full.
		key_pool.delete();
		key_pool.push_back(32'h0000_0000);
		key_pool.push_back(32'hFFFF_FFFF);
		for (int i = 0; i < span + span / 2; i++)
			key_pool.push_back($urandom);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				mode = MODE_ALLOC;
				key = $urandom;
			end else if (pick < 10) begin
				mode = MODE_FREE;
				key = $urandom;
			end else begin
				mode = ($urandom_range(0, 99) < 58) ? MODE_ALLOC : MODE_FREE;
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end
			send_request(mode, key, $urandom);
		end
		drain_results();
	endtask

	initial begin
		foreach (shadow_active[i])
			shadow_active[i] = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_ops();
		test_size_edges();
		test_duplicate_keys();
		test_backpressure();
		test_random_phase(7'd64, 260, 1'b1);
		test_random_phase(7'd1, 120, 1'b1);
		test_random_phase(7'd127, 260, 1'b1);
		test_random_phase(7'd16, 230, 1'b1);
		test_random_phase(7'd0, 40, 1'b1);
		test_random_phase(7'd64, 260, 1'b1);
		test_random_phase(7'd5, 150, 1'b1);
		test_random_phase(7'd40, 260, 1'b1);
		test_random_phase(7'd64, 270, 1'b0);

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
